@@ hdl/lca_pkg.sv @@
// Shared constants, types and helper functions for the life automaton row stepper.
// No dependencies; every other file of the block imports this package.
package lca_pkg;

    localparam int ROW_W        = 64;
    localparam int MAX_WIDTH    = 64;
    localparam int CFG_W        = 7;
    localparam int LANE_COLS    = 8;
    localparam int NUM_LANES    = (MAX_WIDTH + LANE_COLS - 1) / LANE_COLS;
    localparam int PAD_W        = NUM_LANES * LANE_COLS + 2;
    localparam int NB_W         = 4;
    localparam int BIRTH_COUNT  = 3;
    localparam int SURVIVE_MIN  = 2;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
    localparam int CNT_W        = $clog2(FIFO_DEPTH + 1);

    localparam logic [CFG_W-1:0] BOARD_WIDTH_RESET = CFG_W'(64);

    typedef logic [ROW_W-1:0] row_t;

    // Columns below the configured width and below MAX_WIDTH are live.
    function automatic row_t column_mask(input logic [CFG_W-1:0] width);
        row_t m;
        m = '0;
        for (int c = 0; c < ROW_W; c++) begin
            m[c] = (CFG_W'(c) < width) && (c < MAX_WIDTH);
        end
        return m;
    endfunction

endpackage

@@ hdl/lca_lane.sv @@
// One lane of the row evaluator: applies the B3/S23 rule to LANE_COLS adjacent columns.
// Depends on lca_pkg. Each row slice carries one halo column on either side.
module lca_lane
    import lca_pkg::*;
(
    input  logic [LANE_COLS+1:0] up,
    input  logic [LANE_COLS+1:0] mid,
    input  logic [LANE_COLS+1:0] down,
    output logic [LANE_COLS-1:0] cells
);

    logic [NB_W-1:0] nb_count [LANE_COLS];

    always_comb begin
        for (int j = 0; j < LANE_COLS; j++) begin
            nb_count[j] = NB_W'(up[j]) + NB_W'(up[j+1]) + NB_W'(up[j+2])
                        + NB_W'(mid[j]) + NB_W'(mid[j+2])
                        + NB_W'(down[j]) + NB_W'(down[j+1]) + NB_W'(down[j+2]);
            cells[j] = (nb_count[j] == NB_W'(BIRTH_COUNT))
                     || (mid[j+1] && (nb_count[j] == NB_W'(SURVIVE_MIN)));
        end
    end

endmodule

@@ hdl/lca_row_eval.sv @@
// Next-generation row evaluator: splits three rows across parallel lanes and merges the result.
// Depends on lca_pkg and lca_lane.
module lca_row_eval
    import lca_pkg::*;
(
    input  row_t up,
    input  row_t mid,
    input  row_t down,
    input  row_t mask,
    output row_t next_row
);

    logic [PAD_W-1:0]               up_pad;
    logic [PAD_W-1:0]               mid_pad;
    logic [PAD_W-1:0]               down_pad;
    logic [NUM_LANES*LANE_COLS-1:0] lane_out;

    // Padded bit i holds column i-1, so both board edges see dead neighbours.
    always_comb begin
        up_pad   = '0;
        mid_pad  = '0;
        down_pad = '0;
        up_pad[MAX_WIDTH:1]   = up[MAX_WIDTH-1:0];
        mid_pad[MAX_WIDTH:1]  = mid[MAX_WIDTH-1:0];
        down_pad[MAX_WIDTH:1] = down[MAX_WIDTH-1:0];
    end

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
        lca_lane u_lane (
            .up    (up_pad[l*LANE_COLS +: LANE_COLS+2]),
            .mid   (mid_pad[l*LANE_COLS +: LANE_COLS+2]),
            .down  (down_pad[l*LANE_COLS +: LANE_COLS+2]),
            .cells (lane_out[l*LANE_COLS +: LANE_COLS])
        );
    end

    // Merge the lanes and clear the dead columns.
    always_comb begin
        next_row = '0;
        next_row[MAX_WIDTH-1:0] = lane_out[MAX_WIDTH-1:0];
        next_row = next_row & mask;
    end

endmodule

@@ hdl/life_cellular_automaton_row_step.sv @@
// Top level of the life automaton row stepper (B3/S23, dead cells beyond the board).
// Depends on lca_pkg and lca_row_eval.
//
// Usage: rows of the current generation are sent top to bottom on the s_ channel, one
// row per transfer, with s_last_row high on the bottom row. Each row after the first
// yields the next-generation row above it on the m_ channel; the bottom row yields the
// remaining two rows (or one, for a single-row board), the final one with
// m_end_of_board high. The block then starts afresh for the next board.
// The board width is written on the cfg channel (always ready); the user must write it
// only while the block is idle, which the block itself does not enforce. Columns at or
// beyond it are dead. Reset sets the width to 64 and clears the stored rows.
// Throughput: one row per cycle. All columns are evaluated at once by eight lanes of
// eight columns, so the only limit is the four-entry result queue: s_ready is high while
// it has room for two results. When the receiver stalls, results collect in the queue
// and s_ready falls once fewer than two entries are free; nothing is lost or reordered.
module life_cellular_automaton_row_step
    import lca_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_board_width,
    input  logic             s_valid,
    output logic             s_ready,
    input  row_t             s_row_cells,
    input  logic             s_last_row,
    output logic             m_valid,
    input  logic             m_ready,
    output row_t             m_next_row_cells,
    output logic             m_end_of_board
);

    logic [CFG_W-1:0]   board_width_reg;
    row_t               row_above_reg;
    row_t               row_middle_reg;
    logic               middle_valid_reg;
    row_t               fifo_row_reg [FIFO_DEPTH];
    logic               fifo_eob_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [FIFO_AW-1:0] wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_next;
    logic [CNT_W-1:0]   count_next;

    row_t               mask;
    row_t               row_in;
    row_t               res_mid;
    row_t               res_last;
    logic               in_xfer;
    logic               out_xfer;
    logic [CNT_W-1:0]   push_cnt;
    logic [FIFO_AW-1:0] last_slot;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            board_width_reg <= BOARD_WIDTH_RESET;
        end else if (cfg_valid && cfg_ready) begin
            board_width_reg <= cfg_board_width;
        end
    end

    // Incoming bits in dead columns are cleared before they are stored or used.
    assign mask   = column_mask(board_width_reg);
    assign row_in = s_row_cells & mask;

    // The row above the incoming one, and the bottom row with a dead row below it.
    lca_row_eval u_eval_mid (
        .up       (row_above_reg),
        .mid      (row_middle_reg),
        .down     (row_in),
        .mask     (mask),
        .next_row (res_mid)
    );

    lca_row_eval u_eval_last (
        .up       (row_middle_reg),
        .mid      (row_in),
        .down     ('0),
        .mask     (mask),
        .next_row (res_last)
    );

    assign s_ready  = (count_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign in_xfer  = s_valid && s_ready;
    assign m_valid  = (count_reg != '0);
    assign out_xfer = m_valid && m_ready;

    // A pending middle row gives one result; the bottom row gives one more.
    assign push_cnt  = in_xfer ? (CNT_W'(middle_valid_reg) + CNT_W'(s_last_row)) : '0;
    assign last_slot = wr_ptr_reg + FIFO_AW'(middle_valid_reg);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(push_cnt);
        rd_ptr_next = rd_ptr_reg + FIFO_AW'(out_xfer);
        count_next  = count_reg + push_cnt - CNT_W'(out_xfer);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_above_reg    <= '0;
            row_middle_reg   <= '0;
            middle_valid_reg <= 1'b0;
            wr_ptr_reg       <= '0;
            rd_ptr_reg       <= '0;
            count_reg        <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            if (in_xfer) begin
                if (s_last_row) begin
                    // The board is complete, so the next row starts a new one.
                    row_above_reg    <= '0;
                    row_middle_reg   <= '0;
                    middle_valid_reg <= 1'b0;
                end else begin
                    row_above_reg    <= row_middle_reg;
                    row_middle_reg   <= row_in;
                    middle_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer && middle_valid_reg) begin
            fifo_row_reg[wr_ptr_reg] <= res_mid;
            fifo_eob_reg[wr_ptr_reg] <= 1'b0;
        end
        if (in_xfer && s_last_row) begin
            fifo_row_reg[last_slot] <= res_last;
            fifo_eob_reg[last_slot] <= 1'b1;
        end
    end

    assign m_next_row_cells = fifo_row_reg[rd_ptr_reg];
    assign m_end_of_board   = fifo_eob_reg[rd_ptr_reg];

    // The queue never holds more results than it has entries.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overfilled");

    // After the bottom row the stored rows are cleared for the next board.
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && s_last_row) |=> (!middle_valid_reg && (row_middle_reg == '0)))
        else $error("row state not cleared after last row");

    // A middle row followed by another row must add exactly one result.
    a_one_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && !s_last_row && middle_valid_reg && !out_xfer)
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("result not queued for pending middle row");

endmodule
